// ----- design/bitmap_chunk_allocator_assert.svh -----
// Assertion macros for the bitmap chunk allocator.
`ifndef BITMAP_CHUNK_ALLOCATOR_ASSERT_SVH
`define BITMAP_CHUNK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define BCA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BCA_ASSERT(label, clk, rst_n, prop, msg)
`define BCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/bca_pkg.sv -----
// Package for the bitmap chunk allocator: types, constants, status codes.
package bca_pkg;
  localparam int unsigned MaxUnitsDefault = 64;
  localparam int unsigned AlignDefault = 8;
  localparam int unsigned SlotsPerUnit = 64;
  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned AddrW = 26;
  localparam int unsigned CfgW = 24;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgChunkSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRegionBase = 1'b1;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree = 1'b1;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StTooLarge = 3'd1;
  localparam logic [2:0] StNoUnits = 3'd2;
  localparam logic [2:0] StBadAddr = 3'd3;
  localparam logic [2:0] StNotAlloc = 3'd4;

  typedef struct packed {
    logic        func;
    logic [15:0] req_size;
    logic [25:0] chunk_addr;
  } req_t;

  typedef struct packed {
    logic [25:0] alloc_addr;
    logic [2:0]  status;
    logic [12:0] live_chunks;
    logic [6:0]  units_open;
    logic [31:0] total_allocs;
    logic [31:0] total_frees;
  } rsp_t;
endpackage

// ----- design/bca_ram.sv -----
// Generic single-port-write, registered-read RAM.
module bca_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- design/bca_divider.sv -----
// Restoring divider: unit index and in-unit offset of a region offset.
module bca_divider #(
  parameter int unsigned NumW = 26,
  parameter int unsigned DenW = 26
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o,
  output logic [DenW-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [NumW-1:0] quot_q;
  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   shifted;
  logic [DenW:0]   diff;

  assign shifted = {rem_q[DenW-1:0], quot_q[NumW-1]};
  assign diff = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!diff[DenW]) begin
        rem_q <= diff;
        quot_q <= {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quot_q <= {quot_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign quot_o = quot_q;
  assign rem_o = rem_q[DenW-1:0];
endmodule

// ----- design/bitmap_chunk_allocator.sv -----
// Top level of the bitmap chunk allocator.
//
// Channel  Dir  Handshake            Payload
// req      in   req_valid_i/stall_o  bca_pkg::req_t
// rsp      out  rsp_valid_o/stall_i  bca_pkg::rsp_t
// cfg      in   cfg_we_i             cfg_idx_i, cfg_data_i
//
// One transaction at a time. Allocate with a free unit known: bitmap read,
// lowest-bit search and write, result; opening a new unit adds a read state
// (S_ARD) first. When a unit fills, the first-free pointer scan visits S_SCAN
// and S_SCHK for each bitmap entry after it up to the open unit count. Free:
// two bit-serial divides (unit size, then chunk size), each with a start, then
// a bitmap read-modify-write. Reset runs a clearing pass that sets all
// MAX_UNITS bitmap words to all ones; no request is accepted meanwhile.
// A stalled result holds in the output register while the next request is
// taken.
module bitmap_chunk_allocator #(
  parameter int unsigned MAX_UNITS = bca_pkg::MaxUnitsDefault,
  parameter int unsigned ALIGN = bca_pkg::AlignDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  output logic                             stall_o,
  input  bca_pkg::req_t                    req_i,
  output logic                             rsp_valid_o,
  input  logic                             stall_i,
  output bca_pkg::rsp_t                    rsp_o,
  input  logic                             cfg_we_i,
  input  logic [bca_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bca_pkg::CfgW-1:0]         cfg_data_i
);
  import bca_pkg::*;
`include "bitmap_chunk_allocator_assert.svh"

  localparam int unsigned UW = $clog2(MAX_UNITS) > 0 ? $clog2(MAX_UNITS) : 1;
  localparam int unsigned CW = $clog2(MAX_UNITS + 1);
  localparam int unsigned AlignW = $clog2(ALIGN);
  localparam int unsigned DenW = 20; // unit size 8 + 64*8192 fits

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ARD, S_AMOD, S_SCAN, S_SCHK, S_DIV1, S_DIV2,
    S_FRD, S_FMOD, S_OUT
  } state_e;

  state_e state_q;

  logic [12:0] chunk_size_q;
  logic [23:0] region_base_q;
  logic        first_valid_q;
  logic [UW-1:0] first_q;
  logic [CW-1:0] open_q;
  logic [12:0] live_q;
  logic [31:0] allocs_q, frees_q;
  req_t        req_q;
  logic        rsp_valid_q;
  rsp_t        rsp_q;
  logic [UW-1:0] cur_q;
  logic [5:0]  slot_q;
  logic [2:0]  st_q;
  logic [25:0] addr_q;
  logic [CW-1:0] scan_q;
  logic [UW-1:0] clr_q;
  logic [25:0] within_q;

  // rounded chunk size
  logic [12:0] cs1;
  logic [13:0] csz;
  logic [DenW-1:0] unit_bytes;
  assign cs1 = (chunk_size_q == '0) ? 13'd0 : chunk_size_q - 13'd1;
  assign csz = (14'({cs1 >> AlignW}) + 14'd1) << AlignW;
  assign unit_bytes = DenW'(HeaderBytes) + (DenW'(csz) << 6);

  // memory
  logic          we;
  logic [UW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;
  bca_ram #(.Width(64), .Depth(MAX_UNITS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // lowest set bit of the read word
  logic [5:0] low;
  always_comb begin
    low = 6'd63;
    for (int i = 63; i >= 0; i--) begin
      if (rdata[i]) low = 6'(i);
    end
  end

  // divider
  logic          div_start, div_done;
  logic [25:0]   div_num, div_q;
  logic [DenW-1:0] div_den, div_r;
  bca_divider #(.NumW(26), .DenW(DenW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
    .den_i(div_den), .done_o(div_done), .quot_o(div_q), .rem_o(div_r)
  );

  logic [25:0] off;
  assign off = req_q.chunk_addr - 26'(region_base_q);

  // slot address product: unit*unit_bytes + slot*csz, modulo the field width
  logic [25:0] unit_off, slot_off;
  assign unit_off = 26'(cur_q) * 26'(unit_bytes);
  assign slot_off = 26'(20'(slot_q) * 20'(csz));

  logic accept;
  assign accept = req_valid_i && !stall_o;
  assign stall_o = (state_q != S_IDLE);

  always_comb begin
    we = 1'b0;
    waddr = cur_q;
    wdata = rdata;
    raddr = cur_q;
    div_start = 1'b0;
    div_num = off;
    div_den = unit_bytes;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_q; wdata = '1;
      end
      S_IDLE: raddr = first_q;
      S_AMOD: begin
        we = 1'b1; wdata = rdata & ~(64'd1 << low);
      end
      S_SCAN: raddr = scan_q[UW-1:0];
      S_DIV1: div_start = !div_done && (st_q == StOk) && (scan_q == '0);
      S_DIV2: begin
        div_start = (scan_q == CW'(1));
        div_num = within_q - 26'(HeaderBytes);
        div_den = DenW'(csz);
      end
      S_FMOD: begin
        we = (st_q == StOk) && !rdata[slot_q];
        wdata = rdata | (64'd1 << slot_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      chunk_size_q <= 13'd8;
      region_base_q <= '0;
      first_valid_q <= 1'b0;
      first_q <= '0;
      open_q <= '0;
      live_q <= '0;
      allocs_q <= '0;
      frees_q <= '0;
      rsp_valid_q <= 1'b0;
      scan_q <= '0;
      st_q <= StOk;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgChunkSize:  chunk_size_q <= cfg_data_i[12:0];
          CfgRegionBase: region_base_q <= cfg_data_i;
          default: ;
        endcase
      end
      // output register: load a new result once the old one has gone
      if (state_q == S_OUT && (!rsp_valid_q || !stall_i)) begin
        rsp_valid_q <= 1'b1;
      end else if (!stall_i) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == UW'(MAX_UNITS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (accept) begin
          addr_q <= '0;
          if (req_i.func == FuncAlloc) begin
            if (17'(req_i.req_size) > 17'(csz)) begin
              st_q <= StTooLarge; state_q <= S_OUT;
            end else if (!first_valid_q && open_q >= CW'(MAX_UNITS)) begin
              st_q <= StNoUnits; state_q <= S_OUT;
            end else if (!first_valid_q) begin
              // new unit: its word is still all ones from the clearing pass;
              // read it anyway
              st_q <= StOk;
              cur_q <= open_q[UW-1:0];
              first_q <= open_q[UW-1:0];
              first_valid_q <= 1'b1;
              open_q <= open_q + 1'b1;
              state_q <= S_ARD;
            end else begin
              st_q <= StOk;
              cur_q <= first_q;
              state_q <= S_AMOD;
            end
          end else begin
            scan_q <= '0;
            st_q <= (req_i.chunk_addr < 26'(region_base_q)) ? StBadAddr : StOk;
            state_q <= S_DIV1;
          end
        end
        S_ARD: state_q <= S_AMOD;
        S_AMOD: begin
          slot_q <= low;
          live_q <= live_q + 1'b1;
          allocs_q <= allocs_q + 1'b1;
          if ((rdata & ~(64'd1 << low)) == '0) begin
            scan_q <= CW'(cur_q) + 1'b1;
            state_q <= S_SCAN;
          end else begin
            state_q <= S_OUT;
          end
          addr_q <= 26'(region_base_q) + 26'(HeaderBytes);
        end
        S_SCAN: begin
          if (scan_q >= open_q) begin
            first_valid_q <= 1'b0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (rdata != '0) begin
            first_q <= scan_q[UW-1:0];
            state_q <= S_OUT;
          end else begin
            scan_q <= scan_q + 1'b1;
            state_q <= S_SCAN;
          end
        end
        S_DIV1: begin
          if (st_q != StOk) begin
            state_q <= S_OUT;
          end else if (scan_q == '0) begin
            scan_q <= CW'(1);
          end else if (div_done) begin
            within_q <= 26'(div_r);
            if (div_q >= 26'(open_q) || div_r < DenW'(HeaderBytes)) begin
              st_q <= StBadAddr; state_q <= S_OUT;
            end else begin
              cur_q <= div_q[UW-1:0];
              scan_q <= CW'(1);
              state_q <= S_DIV2;
            end
          end
        end
        S_DIV2: begin
          if (scan_q == CW'(1)) begin
            scan_q <= '0;
          end else if (div_done) begin
            slot_q <= div_q[5:0];
            if (div_r != '0) begin
              st_q <= StBadAddr; state_q <= S_OUT;
            end else begin
              state_q <= S_FRD;
            end
          end
        end
        S_FRD: state_q <= S_FMOD;
        S_FMOD: begin
          if (rdata[slot_q]) begin
            st_q <= StNotAlloc;
          end else begin
            live_q <= live_q - 1'b1;
            frees_q <= frees_q + 1'b1;
            if (!first_valid_q || cur_q < first_q) begin
              first_q <= cur_q;
              first_valid_q <= 1'b1;
            end
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid_q || !stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    if (state_q == S_OUT && (!rsp_valid_q || !stall_i)) begin
      rsp_q.alloc_addr <= (st_q == StOk && req_q.func == FuncAlloc)
                          ? addr_q + unit_off + slot_off : '0;
      rsp_q.status <= st_q;
      rsp_q.live_chunks <= live_q;
      rsp_q.units_open <= 7'(open_q);
      rsp_q.total_allocs <= allocs_q;
      rsp_q.total_frees <= frees_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;

  `BCA_ASSERT(a_open_le_max, clk_i, rst_ni, open_q <= CW'(MAX_UNITS), "open units overflow")
  `BCA_ASSERT(a_first_lt_open, clk_i, rst_ni, !first_valid_q || CW'(first_q) < open_q, "first-free beyond open")
  `BCA_ASSERT_NEXT(a_no_accept_busy, clk_i, rst_ni, state_q != S_IDLE, !accept || state_q == S_IDLE, "accept while busy")
endmodule

// ----- tb/bitmap_chunk_allocator_checker.sv -----
// Watches the request and result channels, predicts each result, and counts mismatches.
`timescale 1ns / 100ps

module bitmap_chunk_allocator_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  logic                        req_stall_i,
  input  bca_pkg::req_t               req_i,
  input  logic                        rsp_valid_i,
  input  logic                        rsp_stall_i,
  input  bca_pkg::rsp_t               rsp_i,
  input  logic                        cfg_we_i,
  input  logic [bca_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bca_pkg::CfgW-1:0]    cfg_data_i,
  output int                          errors_o,
  output int                          pending_o
);
  import bca_pkg::*;

  localparam int Units = MaxUnitsDefault;

  logic [63:0] unit_free_bits [Units];
  logic        first_ok;
  int unsigned first_unit;
  int unsigned units_opened;
  logic [12:0] live_chunks;
  logic [31:0] alloc_total;
  logic [31:0] free_total;
  logic [12:0] chunk_size_q;
  logic [23:0] region_base_q;
  rsp_t        expected_rsps [$];

  function automatic rsp_t allocator_predict(req_t r);
    rsp_t        o;
    longint unsigned csz, ubytes, a, off, idx, in_unit, cs;
    int unsigned j, k;
    o = '0;
    cs = (chunk_size_q == 0) ? 1 : chunk_size_q;
    csz = ((cs - 1) / AlignDefault + 1) * AlignDefault;
    ubytes = HeaderBytes + SlotsPerUnit * csz;
    o.status = StOk;
    if (r.func == FuncAlloc) begin
      if (r.req_size > csz) begin
        o.status = StTooLarge;
      end else if (!first_ok && units_opened >= Units) begin
        o.status = StNoUnits;
      end else begin
        if (!first_ok) begin
          unit_free_bits[units_opened] = '1;
          first_unit = units_opened;
          first_ok = 1'b1;
          units_opened++;
        end
        j = 0;
        while (j < 63 && !unit_free_bits[first_unit][j]) j++;
        unit_free_bits[first_unit][j] = 1'b0;
        a = region_base_q + HeaderBytes + first_unit * ubytes + j * csz;
        o.alloc_addr = a[25:0];
        live_chunks++;
        alloc_total++;
        if (unit_free_bits[first_unit] == 0) begin
          k = first_unit + 1;
          while (k < units_opened && unit_free_bits[k] == 0) k++;
          if (k < units_opened) first_unit = k;
          else first_ok = 1'b0;
        end
      end
    end else begin
      a = r.chunk_addr;
      if (a < region_base_q) begin
        o.status = StBadAddr;
      end else begin
        off = a - region_base_q;
        idx = off / ubytes;
        in_unit = off - idx * ubytes;
        if (idx >= units_opened || in_unit < HeaderBytes || (in_unit - HeaderBytes) % csz != 0)
        begin
          o.status = StBadAddr;
        end else begin
          j = 32'((in_unit - HeaderBytes) / csz);
          if (unit_free_bits[idx][j[5:0]]) begin
            o.status = StNotAlloc;
          end else begin
            unit_free_bits[idx][j[5:0]] = 1'b1;
            live_chunks--;
            free_total++;
            if (!first_ok || idx < first_unit) begin
              first_unit = 32'(idx);
              first_ok = 1'b1;
            end
          end
        end
      end
    end
    o.live_chunks = live_chunks;
    o.units_open = units_opened[6:0];
    o.total_allocs = alloc_total;
    o.total_frees = free_total;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Units; i++) unit_free_bits[i] = '1;
      first_ok = 1'b0;
      first_unit = 0;
      units_opened = 0;
      live_chunks = '0;
      alloc_total = '0;
      free_total = '0;
      chunk_size_q = 13'd8;
      region_base_q = '0;
      errors_o = 0;
      expected_rsps.delete();
      pending_o = 0;
    end else begin
      if (rsp_valid_i && !rsp_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: result with none expected: %p", $time, rsp_i);
          errors_o++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_i !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, rsp_i);
            errors_o++;
          end
        end
      end
      if (req_valid_i && !req_stall_i) expected_rsps.push_back(allocator_predict(req_i));
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgChunkSize) chunk_size_q = cfg_data_i[12:0];
        else region_base_q = cfg_data_i;
      end
      pending_o = expected_rsps.size();
    end
  end
endmodule

// ----- tb/bitmap_chunk_allocator_test.sv -----
// Stimulus and verdict for the bitmap chunk allocator.
`timescale 1ns / 100ps

module bitmap_chunk_allocator_test;
  import bca_pkg::*;

  logic                clk, rst_n;
  logic                req_valid, req_stall;
  req_t                req;
  logic                rsp_valid, rsp_stall;
  rsp_t                rsp;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgW-1:0]     cfg_data;
  int                  errors, pending;
  int                  send_idle_pct, recv_idle_pct;
  longint              cycles;

  // Model of the addresses handed out, so frees can target live chunks.
  logic [25:0] live_addrs [$];
  logic [12:0] cur_chunk;
  logic [23:0] cur_base;

  bitmap_chunk_allocator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .req_valid_i(req_valid), .stall_o(req_stall), .req_i(req),
    .rsp_valid_o(rsp_valid), .stall_i(rsp_stall), .rsp_o(rsp),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  bitmap_chunk_allocator_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .req_valid_i(req_valid), .req_stall_i(req_stall), .req_i(req),
    .rsp_valid_i(rsp_valid), .rsp_stall_i(rsp_stall), .rsp_i(rsp),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a long stalled receiver stretches every transaction.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver stall, randomized on the falling edge.
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Track results to learn which addresses are live.
  always @(posedge clk) begin
    if (rst_n && rsp_valid && !rsp_stall && rsp.status == StOk && rsp.alloc_addr != 0)
      live_addrs.push_back(rsp.alloc_addr);
  end

  // Valid stays up after the handshake; the next send replaces or drops it, and drain drops it.
  task automatic send(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic alloc_op(input logic [15:0] sz);
    req_t r;
    r = '0;
    r.func = FuncAlloc;
    r.req_size = sz;
    r.chunk_addr = 26'($urandom);
    send(r);
  endtask

  task automatic free_op(input logic [25:0] a);
    req_t r;
    r = '0;
    r.func = FuncFree;
    r.req_size = 16'($urandom);
    r.chunk_addr = a;
    send(r);
  endtask

  // Wait out every expected result, then the block's tail.
  task automatic drain;
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] d);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CfgChunkSize) cur_chunk = d[12:0];
    else cur_base = d;
  endtask

  function automatic logic [25:0] pick_live(input bit take);
    int          n;
    logic [25:0] a;
    n = int'($urandom_range(live_addrs.size() - 1));
    a = live_addrs[n];
    if (take) live_addrs.delete(n);
    return a;
  endfunction

  task automatic random_phase(input int n);
    int          k;
    logic [25:0] a;
    for (int i = 0; i < n; i++) begin
      k = int'($urandom_range(99));
      if (k < 45) begin
        alloc_op(16'($urandom_range(cur_chunk == 0 ? 1 : cur_chunk)));
      end else if (k < 80 && live_addrs.size() > 0) begin
        free_op(pick_live(1));
      end else if (k < 85 && live_addrs.size() > 0) begin
        a = pick_live(0);
        free_op(26'(a + $urandom_range(1, 7)));
      end else if (k < 92) begin
        alloc_op(16'($urandom));
      end else begin
        free_op(26'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgChunkSize;
    cfg_data = '0;
    send_idle_pct = 13;
    recv_idle_pct = 72;
    cur_chunk = 13'd8;
    cur_base = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (80) @(negedge clk);   // clearing pass

    // Directed: extremes, errors, double free, free with no first-free unit.
    write_cfg(CfgChunkSize, 24'd0);   // counts as 1, rounds to 8
    write_cfg(CfgRegionBase, 24'h000100);
    free_op(26'h0);                   // below base
    free_op(26'h108);                 // unit not open
    alloc_op(16'd8);
    alloc_op(16'd9);                  // too large
    alloc_op(16'hFFFF);
    alloc_op(16'd0);
    free_op(26'h108);                 // live chunk
    free_op(26'h108);                 // double free
    free_op(26'h100);                 // header
    free_op(26'h10C);                 // misaligned
    free_op(26'h3FFFFFF);
    drain();
    live_addrs.delete();

    // Fill three units exactly: the pointer scans to the end and goes to none.
    for (int i = 0; i < 3 * SlotsPerUnit - 1; i++) alloc_op(16'd1);
    free_op(26'h108 + 26'd8);          // free while the pointer is none
    alloc_op(16'd8);
    drain();
    live_addrs.delete();

    // Largest chunk and base extremes, state kept across layouts.
    write_cfg(CfgChunkSize, 24'd4096);
    write_cfg(CfgRegionBase, 24'hFFFFFF);
    send_idle_pct = 72;
    recv_idle_pct = 13;
    random_phase(430);
    drain();

    write_cfg(CfgChunkSize, 24'h001FFF);
    write_cfg(CfgRegionBase, 24'h000000);
    live_addrs.delete();
    random_phase(430);
    drain();

    write_cfg(CfgChunkSize, 24'd24);
    write_cfg(CfgRegionBase, 24'h012340);
    live_addrs.delete();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(430);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+design
design/bca_pkg.sv
design/bca_ram.sv
design/bca_divider.sv
design/bitmap_chunk_allocator.sv
tb/bitmap_chunk_allocator_checker.sv
tb/bitmap_chunk_allocator_test.sv
